// ===== sv/tlle_pkg.sv =====
// Shared types and constants of the text line layout engine.
package tlle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ColorW = 32;
  localparam int unsigned LineW  = 16;
  localparam int unsigned ColW   = 8;
  localparam int unsigned TotW   = 14;
  localparam int unsigned GidxW  = 7;
  localparam int unsigned CntW   = 8;
  localparam int unsigned MlW    = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [ColorW-1:0] color_t;
  typedef logic [LineW-1:0]  line_t;
  typedef logic [ColW-1:0]   col_t;
  typedef logic [TotW-1:0]   total_t;
  typedef logic [GidxW-1:0]  gidx_t;
  typedef logic [CntW-1:0]   cnt_t;

  // Request kinds
  typedef enum logic {
    ReqText  = 1'b0,
    ReqClear = 1'b1
  } req_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxChars = 2'd0,
    CfgMaxLines = 2'd1
  } cfg_idx_e;

  // Character codes
  localparam byte_t ChrTab   = 8'h09;
  localparam byte_t ChrLf    = 8'h0A;
  localparam byte_t ChrCr    = 8'h0D;
  localparam byte_t ChrSpace = 8'h20;
  localparam byte_t ChrTilde = 8'h7E;

  // Atlas index of the substitute glyph '?'
  localparam gidx_t GlyphQmark = 7'd31;

  // Column limit used when the register holds zero
  localparam col_t ColMax = 8'd255;

  // Payload of one result beat
  typedef struct packed {
    logic   glyph_valid;
    gidx_t  glyph_index;
    color_t glyph_color;
    line_t  line_number;
    col_t   column;
    line_t  first_line;
    total_t glyph_total;
  } out_t;

  // Work handed from the layout stage to the glyph total stage
  typedef struct packed {
    logic   res;       // produces a result beat
    logic   clr;       // clear request
    logic   drop;      // oldest line dropped
    logic   fwd;       // dropped line was the head line, count taken from fwd_cnt
    logic   inc;       // one visible glyph added
    cnt_t   fwd_cnt;
    logic   glyph_valid;
    gidx_t  glyph_index;
    color_t glyph_color;
    line_t  line_number;
    col_t   column;
    line_t  first_line;
  } s2_t;

endpackage

// ===== sv/tlle_if.sv =====
// Channel interfaces of the text line layout engine.
interface tlle_in_if;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  tlle_pkg::byte_t       text_byte;
  tlle_pkg::color_t      text_color;

  modport source (output valid, req_type, text_byte, text_color, input ready);
  modport sink   (input valid, req_type, text_byte, text_color, output ready);
endinterface

interface tlle_out_if;
  logic                  valid;
  logic                  ready;
  logic                  glyph_valid;
  tlle_pkg::gidx_t       glyph_index;
  tlle_pkg::color_t      glyph_color;
  tlle_pkg::line_t       line_number;
  tlle_pkg::col_t        column;
  tlle_pkg::line_t       first_line;
  tlle_pkg::total_t      glyph_total;

  modport source (output valid, glyph_valid, glyph_index, glyph_color, line_number, column,
                  first_line, glyph_total, input ready);
  modport sink   (input valid, glyph_valid, glyph_index, glyph_color, line_number, column,
                  first_line, glyph_total, output ready);
endinterface

interface tlle_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tlle_pkg::CfgIdxW-1:0]      index;
  logic [tlle_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tlle_cnt_ram.sv =====
// Glyph count memory of the line ring: one write port, one registered read port.
module tlle_cnt_ram #(
  parameter int unsigned Depth = 64
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  tlle_pkg::cnt_t                      wr_data_i,
  input  logic                                rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output tlle_pkg::cnt_t                      rd_data_o
);

  tlle_pkg::cnt_t mem_q [Depth];
  tlle_pkg::cnt_t rd_data_q;

  // Write closed line counts
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read the oldest line count, hold it until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/text_line_layout_engine_unit.sv =====
// Text line layout engine: places a byte stream into numbered character-cell lines.
// The block takes one byte (or clear request) per clock cycle unless a held result or a trim
// sweep holds it off, and returns one result beat per item through the second stage and the
// output register, which lets the next byte in while a result still waits. Line, column and
// ring pointers update in the layout stage; the glyph count of each closed line lives in a
// LineSlots-entry RAM whose single read port fetches the count of the line being dropped, and
// the kept glyph total is settled in the second stage from that read or the forwarded head
// count. After a write of max_lines the input stalls while the oldest lines that must go are dropped.
module text_line_layout_engine_unit #(
  parameter int unsigned LineSlots = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlle_in_if.sink    text_in_i,
  tlle_out_if.source glyph_out_o,
  tlle_cfg_if.sink   cfg_i
);

  localparam int unsigned PW = (LineSlots > 1) ? $clog2(LineSlots) : 1;
  localparam int unsigned HW = $clog2(LineSlots + 1);
  localparam int unsigned LW = (HW > tlle_pkg::MlW) ? HW : tlle_pkg::MlW;
  localparam int unsigned ColW9 = tlle_pkg::ColW + 1;
  localparam logic [PW-1:0] LastSlot = PW'(LineSlots - 1);
  localparam logic [HW-1:0] FullHeld = HW'(LineSlots);
  localparam logic [HW-1:0] OneHeld  = HW'(1);
  localparam logic [LW-1:0] LimitMax = LW'(LineSlots);

  // Configuration
  tlle_pkg::col_t          mcl_q;
  logic [tlle_pkg::MlW-1:0] ml_q;
  logic                    trim_pend_q, trim_pend_d;

  // Layout state
  tlle_pkg::line_t cur_q, cur_d;
  tlle_pkg::col_t  col_q, col_d;
  tlle_pkg::line_t old_q, old_d;
  logic [HW-1:0]   held_q, held_d;
  logic [PW-1:0]   head_q, head_d;
  logic [PW-1:0]   tail_q, tail_d;
  tlle_pkg::cnt_t  head_cnt_q, head_cnt_d;
  tlle_pkg::total_t kept_q;

  // Pipeline
  logic            s2_v_q;
  tlle_pkg::s2_t   s2_q, s2_d;
  logic            out_v_q;
  tlle_pkg::out_t  out_q;

  // Control
  logic cfg_wr, in_acc, s1_free, s2_move, s2_load, sweep_go, trim_need;
  logic do_open, tab_adv, placed, ring_drop, trim_drop, vis, printable;
  tlle_pkg::col_t  lim, col_o, col_fin;
  tlle_pkg::line_t cur_o;
  logic [HW-1:0]   held_o;
  logic [LW-1:0]   limit, ml_ext, eff, eff_r;
  logic [ColW9-1:0] m9;
  tlle_pkg::gidx_t gidx;
  tlle_pkg::byte_t tb;

  // RAM ports
  logic           wr_en, rd_en;
  tlle_pkg::cnt_t rd_data, drop_cnt;
  tlle_pkg::total_t kept_d;

  function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] p);
    return (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  // Configuration writes
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcl_q <= '0;
      ml_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        tlle_pkg::CfgMaxChars: mcl_q <= cfg_i.data;
        tlle_pkg::CfgMaxLines: ml_q  <= cfg_i.data[tlle_pkg::MlW-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits
  assign ml_ext = LW'(ml_q);
  assign limit  = (ml_q == '0 || ml_ext > LimitMax) ? LimitMax : ml_ext;
  assign lim    = (mcl_q == '0) ? tlle_pkg::ColMax : mcl_q;

  // Handshake
  assign s2_move  = s2_v_q && (!s2_q.res || !out_v_q || glyph_out_o.ready);
  assign s1_free  = !s2_v_q || s2_move;
  assign text_in_i.ready = s1_free && !trim_pend_q;
  assign in_acc   = text_in_i.valid && text_in_i.ready;

  // Trim check on the held state, used by the sweep after a limit change
  assign eff_r     = LW'(held_q) - LW'(col_q == '0);
  assign trim_need = (eff_r > limit) && (held_q > OneHeld);
  assign sweep_go  = trim_pend_q && s1_free && trim_need;
  assign s2_load   = in_acc || sweep_go;

  always_comb begin
    trim_pend_d = trim_pend_q;
    if (trim_pend_q && s1_free && !trim_need) begin
      trim_pend_d = 1'b0;
    end
    if (cfg_wr && cfg_i.index == tlle_pkg::CfgMaxLines) begin
      trim_pend_d = 1'b1;
    end
  end

  // Decode the byte against the current line
  assign tb = text_in_i.text_byte;
  assign m9 = ({1'b0, col_q} | ColW9'(3)) + ColW9'(1);
  assign printable = (tb >= tlle_pkg::ChrSpace) && (tb <= tlle_pkg::ChrTilde);

  always_comb begin
    do_open = 1'b0;
    tab_adv = 1'b0;
    placed  = 1'b0;
    case (tb)
      tlle_pkg::ChrLf: do_open = 1'b1;
      tlle_pkg::ChrCr: ;
      tlle_pkg::ChrTab: begin
        if (col_q[1:0] != 2'b00) begin
          if ({1'b0, lim} < m9) begin
            do_open = 1'b1;
          end else begin
            tab_adv = 1'b1;
          end
        end
      end
      default: begin
        placed  = 1'b1;
        do_open = (col_q >= lim);
      end
    endcase
  end

  assign ring_drop = do_open && (held_q >= FullHeld);
  assign held_o    = (do_open && !ring_drop) ? held_q + 1'b1 : held_q;
  assign cur_o     = do_open ? cur_q + 1'b1 : cur_q;
  assign col_o     = do_open ? '0 : col_q;
  assign vis       = placed && (!printable || tb != tlle_pkg::ChrSpace);
  assign gidx      = printable ? tlle_pkg::GidxW'(tb - tlle_pkg::ChrSpace)
                               : tlle_pkg::GlyphQmark;
  assign col_fin   = placed ? col_o + 1'b1 : (tab_adv ? m9[tlle_pkg::ColW-1:0] : col_o);
  assign eff       = LW'(held_o) - LW'(col_fin == '0);
  assign trim_drop = !ring_drop && (eff > limit) && (held_o > OneHeld);

  // Layout stage: next state, RAM access and stage-two work
  always_comb begin
    cur_d      = cur_q;
    col_d      = col_q;
    old_d      = old_q;
    held_d     = held_q;
    head_d     = head_q;
    tail_d     = tail_q;
    head_cnt_d = head_cnt_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s2_d       = '0;
    if (in_acc) begin
      s2_d.res = 1'b1;
      if (text_in_i.req_type == tlle_pkg::ReqClear) begin
        cur_d      = '0;
        col_d      = '0;
        old_d      = '0;
        held_d     = OneHeld;
        head_d     = '0;
        tail_d     = '0;
        head_cnt_d = '0;
        s2_d.clr   = 1'b1;
      end else begin
        cur_d  = cur_o;
        col_d  = col_fin;
        held_d = held_o;
        if (do_open) begin
          head_d     = slot_next(head_q);
          wr_en      = 1'b1;
          head_cnt_d = '0;
        end
        if (vis) begin
          head_cnt_d = (do_open ? '0 : head_cnt_q) + 1'b1;
        end
        s2_d.inc = vis;
        if (ring_drop || trim_drop) begin
          // A ring drop makes room for the opened line, so the held count stays
          tail_d       = slot_next(tail_q);
          old_d        = old_q + 1'b1;
          held_d       = ring_drop ? held_o : held_o - 1'b1;
          rd_en        = 1'b1;
          s2_d.drop    = 1'b1;
          s2_d.fwd     = trim_drop && (held_q == OneHeld);
          s2_d.fwd_cnt = head_cnt_q;
        end
        s2_d.glyph_valid = vis;
        s2_d.glyph_index = placed ? gidx : '0;
        s2_d.glyph_color = placed ? text_in_i.text_color : '0;
        s2_d.line_number = cur_o;
        s2_d.column      = placed ? col_o : '0;
        s2_d.first_line  = old_d;
      end
    end else if (sweep_go) begin
      tail_d    = slot_next(tail_q);
      old_d     = old_q + 1'b1;
      held_d    = held_q - 1'b1;
      rd_en     = 1'b1;
      s2_d.drop = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      col_q       <= '0;
      old_q       <= '0;
      held_q      <= OneHeld;
      head_q      <= '0;
      tail_q      <= '0;
      head_cnt_q  <= '0;
      trim_pend_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      col_q       <= col_d;
      old_q       <= old_d;
      held_q      <= held_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      head_cnt_q  <= head_cnt_d;
      trim_pend_q <= trim_pend_d;
    end
  end

  tlle_cnt_ram #(
    .Depth (LineSlots)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (head_q),
    .wr_data_i (head_cnt_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (tail_q),
    .rd_data_o (rd_data)
  );

  // Glyph total stage
  assign drop_cnt = s2_q.fwd ? s2_q.fwd_cnt : rd_data;
  assign kept_d   = s2_q.clr ? '0
                  : kept_q - (s2_q.drop ? tlle_pkg::TotW'(drop_cnt) : '0)
                    + tlle_pkg::TotW'(s2_q.inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      kept_q  <= '0;
    end else begin
      if (s2_load) begin
        s2_v_q <= 1'b1;
      end else if (s2_move) begin
        s2_v_q <= 1'b0;
      end
      if (s2_move) begin
        kept_q <= kept_d;
      end
      if (s2_move && s2_q.res) begin
        out_v_q <= 1'b1;
      end else if (glyph_out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_q <= s2_d;
    end
    if (s2_move && s2_q.res) begin
      out_q.glyph_valid <= s2_q.glyph_valid;
      out_q.glyph_index <= s2_q.glyph_index;
      out_q.glyph_color <= s2_q.glyph_color;
      out_q.line_number <= s2_q.line_number;
      out_q.column      <= s2_q.column;
      out_q.first_line  <= s2_q.first_line;
      out_q.glyph_total <= kept_d;
    end
  end

  // Drive the result beat
  assign glyph_out_o.valid       = out_v_q;
  assign glyph_out_o.glyph_valid = out_q.glyph_valid;
  assign glyph_out_o.glyph_index = out_q.glyph_index;
  assign glyph_out_o.glyph_color = out_q.glyph_color;
  assign glyph_out_o.line_number = out_q.line_number;
  assign glyph_out_o.column      = out_q.column;
  assign glyph_out_o.first_line  = out_q.first_line;
  assign glyph_out_o.glyph_total = out_q.glyph_total;

  // Ring pointers agree with the held line count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == OneHeld) == (head_q == tail_q))
    else $error("ring pointers disagree with held line count");

  // Line limit holds whenever no trim sweep is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !trim_pend_q |-> !trim_need)
    else $error("line limit exceeded outside a trim sweep");

  // Clear returns the layout to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && text_in_i.req_type == tlle_pkg::ReqClear
    |=> held_q == OneHeld && cur_q == '0 && old_q == '0 && col_q == '0)
    else $error("clear left layout state behind");

  // No byte enters during a trim sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trim_pend_q |-> !text_in_i.ready)
    else $error("byte accepted during trim sweep");

  // Forwarded counts only stand for a dropped line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && s2_q.fwd |-> s2_q.drop && s2_q.res)
    else $error("forwarded count without a line drop");

endmodule

// ===== tb/sv/text_line_layout_checker.sv =====
// Layout predictor and result comparison for the text line layout engine testbench.
module text_line_layout_checker #(
  parameter int unsigned LineSlots = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlle_in_if   text_in_i,
  tlle_out_if  glyph_out_i,
  tlle_cfg_if  cfg_i,
  output int   mismatch_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 40;

  // Configuration copy, written on each accepted register beat
  tlle_pkg::col_t           wrap_cols;
  logic [tlle_pkg::MlW-1:0] keep_lines;

  // Layout state
  tlle_pkg::line_t  cur_line;
  tlle_pkg::line_t  oldest_line;
  tlle_pkg::col_t   cur_col;
  tlle_pkg::total_t kept_total;
  tlle_pkg::cnt_t   line_cnt [LineSlots];
  int               head_slot;
  int               tail_slot;

  tlle_pkg::out_t   layout_q [$];
  int               mismatches;
  int               waiting;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;

  function automatic int held_count();
    tlle_pkg::line_t span;
    span = cur_line - oldest_line;
    return int'(span) + 1;
  endfunction

  // Drop the oldest line and take its glyphs off the total
  function automatic void drop_oldest_line();
    if (int'(line_cnt[tail_slot]) <= int'(kept_total)) begin
      kept_total = kept_total - tlle_pkg::total_t'(line_cnt[tail_slot]);
    end
    line_cnt[tail_slot] = '0;
    tail_slot   = (tail_slot + 1) % LineSlots;
    oldest_line = oldest_line + 1'b1;
  endfunction

  // Open a fresh line; a full ring loses its oldest line first
  function automatic void open_next_line();
    if (held_count() >= int'(LineSlots)) begin
      drop_oldest_line();
    end
    cur_line  = cur_line + 1'b1;
    head_slot = (head_slot + 1) % LineSlots;
    line_cnt[head_slot] = '0;
    cur_col   = '0;
  endfunction

  function automatic void clear_layout();
    foreach (line_cnt[i]) line_cnt[i] = '0;
    cur_line    = '0;
    cur_col     = '0;
    oldest_line = '0;
    kept_total  = '0;
    head_slot   = 0;
    tail_slot   = 0;
  endfunction

  // Drop oldest lines while too many lines are held, not counting an empty current line
  function automatic void trim_lines();
    int lim;
    int n;
    int eff;
    lim = int'(keep_lines);
    if (lim == 0 || lim > int'(LineSlots)) begin
      lim = LineSlots;
    end
    n   = held_count();
    eff = (cur_col == '0) ? n - 1 : n;
    while (eff > lim && n > 1) begin
      drop_oldest_line();
      n   = held_count();
      eff = (cur_col == '0) ? n - 1 : n;
    end
  endfunction

  // Advance the layout by one request and return the result it yields
  function automatic tlle_pkg::out_t layout_item(tlle_pkg::req_e kind, tlle_pkg::byte_t chr,
                                                 tlle_pkg::color_t color);
    tlle_pkg::out_t r;
    int             lim;
    logic           placed;
    r      = '0;
    placed = 1'b0;
    if (kind == tlle_pkg::ReqClear) begin
      clear_layout();
    end else begin
      lim = (wrap_cols == '0) ? int'(tlle_pkg::ColMax) : int'(wrap_cols);
      if (chr == tlle_pkg::ChrLf) begin
        open_next_line();
      end else if (chr == tlle_pkg::ChrCr) begin
        // carriage return leaves the layout as it is
      end else if (chr == tlle_pkg::ChrTab) begin
        while (cur_col[1:0] != 2'b00) begin
          if (int'(cur_col) >= lim) begin
            open_next_line();
            break;
          end
          cur_col = cur_col + 1'b1;
        end
      end else begin
        if (int'(cur_col) >= lim) begin
          open_next_line();
        end
        placed        = 1'b1;
        r.line_number = cur_line;
        r.column      = cur_col;
        r.glyph_color = color;
        if (chr >= tlle_pkg::ChrSpace && chr <= tlle_pkg::ChrTilde) begin
          r.glyph_index = tlle_pkg::gidx_t'(chr - tlle_pkg::ChrSpace);
          r.glyph_valid = (chr != tlle_pkg::ChrSpace);
        end else begin
          r.glyph_index = tlle_pkg::GlyphQmark;
          r.glyph_valid = 1'b1;
        end
        if (r.glyph_valid) begin
          line_cnt[head_slot] = line_cnt[head_slot] + 1'b1;
          kept_total          = kept_total + 1'b1;
        end
        cur_col = cur_col + 1'b1;
      end
      trim_lines();
    end
    if (!placed) begin
      r.line_number = cur_line;
    end
    r.first_line  = oldest_line;
    r.glyph_total = kept_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < MaxPrinted) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Predict on every accepted request, compare on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    tlle_pkg::out_t got;
    tlle_pkg::out_t want;
    if (!rst_ni) begin
      wrap_cols  = '0;
      keep_lines = '0;
      clear_layout();
      layout_q.delete();
      mismatches = 0;
      waiting    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (tlle_pkg::cfg_idx_e'(cfg_i.index))
          tlle_pkg::CfgMaxChars: begin
            wrap_cols = tlle_pkg::col_t'(cfg_i.data);
          end
          tlle_pkg::CfgMaxLines: begin
            keep_lines = cfg_i.data[tlle_pkg::MlW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (text_in_i.valid && text_in_i.ready) begin
        layout_q.push_back(layout_item(tlle_pkg::req_e'(text_in_i.req_type),
                                       text_in_i.text_byte, text_in_i.text_color));
      end
      if (glyph_out_i.valid && glyph_out_i.ready) begin
        got.glyph_valid = glyph_out_i.glyph_valid;
        got.glyph_index = glyph_out_i.glyph_index;
        got.glyph_color = glyph_out_i.glyph_color;
        got.line_number = glyph_out_i.line_number;
        got.column      = glyph_out_i.column;
        got.first_line  = glyph_out_i.first_line;
        got.glyph_total = glyph_out_i.glyph_total;
        if (layout_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", got.line_number, 0);
        end else begin
          // Take the oldest prediction off the queue
          want = layout_q[0];
          layout_q.delete(0);
          if (got.glyph_valid !== want.glyph_valid)
            report_mismatch("glyph_valid", got.glyph_valid, want.glyph_valid);
          if (got.glyph_index !== want.glyph_index)
            report_mismatch("glyph_index", got.glyph_index, want.glyph_index);
          if (got.glyph_color !== want.glyph_color)
            report_mismatch("glyph_color", got.glyph_color, want.glyph_color);
          if (got.line_number !== want.line_number)
            report_mismatch("line_number", got.line_number, want.line_number);
          if (got.column !== want.column)
            report_mismatch("column", got.column, want.column);
          if (got.first_line !== want.first_line)
            report_mismatch("first_line", got.first_line, want.first_line);
          if (got.glyph_total !== want.glyph_total)
            report_mismatch("glyph_total", got.glyph_total, want.glyph_total);
        end
      end
      waiting = layout_q.size();
    end
  end

endmodule

// ===== tb/sv/text_line_layout_engine_unit_test.sv =====
// Stimulus, clocking and verdict for the text line layout engine.
module text_line_layout_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineSlots  = 64;
  localparam int          IdlePct    = 34;
  localparam int          StallBeats = 120;
  localparam int          OverflowLf = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // No idling on either side while set
  logic steady = 1'b0;
  // Bumped by the stimulus to ask the receiver for one long hold-off
  int   stall_requests = 0;

  int   mismatch_count;
  int   pending_count;

  tlle_in_if  text_ch ();
  tlle_out_if glyph_ch ();
  tlle_cfg_if cfg_ch ();

  text_line_layout_engine_unit #(
    .LineSlots (LineSlots)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_in_i   (text_ch),
    .glyph_out_o (glyph_ch),
    .cfg_i       (cfg_ch)
  );

  text_line_layout_checker #(
    .LineSlots (LineSlots)
  ) u_layout_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_in_i        (text_ch),
    .glyph_out_i      (glyph_ch),
    .cfg_i            (cfg_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always #2 clk_i = ~clk_i;

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_left;
    int stall_taken;
    hold_left   = 0;
    stall_taken = 0;
    glyph_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_requests != stall_taken) begin
        stall_taken = stall_requests;
        hold_left   = StallBeats;
      end
      if (hold_left > 0) begin
        glyph_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        glyph_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Offer one request beat after a random gap, hold until accepted
  task automatic offer(tlle_pkg::req_e kind, tlle_pkg::byte_t chr, tlle_pkg::color_t color);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IdlePct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    text_ch.valid      <= 1'b1;
    text_ch.req_type   <= kind;
    text_ch.text_byte  <= chr;
    text_ch.text_color <= color;
    do @(posedge clk_i); while (!text_ch.ready);
  endtask

  task automatic set_reg(tlle_pkg::cfg_idx_e idx, logic [tlle_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Stop offering and wait until every result is back, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    text_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(logic [tlle_pkg::CfgDataW-1:0] cols,
                           logic [tlle_pkg::CfgDataW-1:0] lines);
    drain();
    set_reg(tlle_pkg::CfgMaxChars, cols);
    set_reg(tlle_pkg::CfgMaxLines, lines);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Byte mix of running text: words, spaces, line breaks, tabs and junk
  function automatic tlle_pkg::byte_t stream_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return tlle_pkg::byte_t'($urandom_range(8'h7E, 8'h21));
    if (pick < 65) return tlle_pkg::ChrSpace;
    if (pick < 75) return tlle_pkg::ChrLf;
    if (pick < 82) return tlle_pkg::ChrTab;
    if (pick < 85) return tlle_pkg::ChrCr;
    if (pick < 93) begin
      if ($urandom_range(1) == 0) return tlle_pkg::byte_t'($urandom_range(8'h1F, 8'h00));
      return tlle_pkg::byte_t'($urandom_range(8'hFF, 8'h7F));
    end
    return tlle_pkg::byte_t'($urandom_range(8'hFF, 8'h00));
  endfunction

  task automatic run_phase(logic [tlle_pkg::CfgDataW-1:0] cols,
                           logic [tlle_pkg::CfgDataW-1:0] lines, int beats, bit squeeze);
    configure(cols, lines);
    if (squeeze) stall_requests++;
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(99) < 2) begin
        offer(tlle_pkg::ReqClear, tlle_pkg::byte_t'($urandom), tlle_pkg::color_t'($urandom));
      end else begin
        offer(tlle_pkg::ReqText, stream_byte(), tlle_pkg::color_t'($urandom));
      end
    end
  endtask

  // Main stimulus
  initial begin
    int lf_sent;
    text_ch.valid      = 1'b0;
    text_ch.req_type   = tlle_pkg::ReqText;
    text_ch.text_byte  = '0;
    text_ch.text_color = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = tlle_pkg::CfgMaxChars;
    cfg_ch.data        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: extremes of byte and color, every byte class
    offer(tlle_pkg::ReqClear, 8'hFF, 32'hFFFF_FFFF);
    offer(tlle_pkg::ReqText, 8'h41, 32'h0000_0000);             // 'A'
    offer(tlle_pkg::ReqText, tlle_pkg::ChrTilde, 32'hFFFF_FFFF);
    offer(tlle_pkg::ReqText, tlle_pkg::ChrSpace, 32'h1234_5678);
    offer(tlle_pkg::ReqText, 8'h00, 32'hA5A5_5A5A);             // zero byte shows as '?'
    offer(tlle_pkg::ReqText, 8'hFF, 32'h5A5A_A5A5);
    offer(tlle_pkg::ReqText, 8'h7F, 32'h0F0F_F0F0);
    offer(tlle_pkg::ReqText, 8'h1F, 32'hF0F0_0F0F);
    offer(tlle_pkg::ReqText, tlle_pkg::ChrCr, 32'hFFFF_FFFF);
    offer(tlle_pkg::ReqText, tlle_pkg::ChrTab, 32'h0000_0001);  // pad from column 7
    offer(tlle_pkg::ReqText, tlle_pkg::ChrTab, 32'h8000_0000);  // already on a tab stop
    offer(tlle_pkg::ReqText, 8'h21, 32'hDEAD_BEEF);             // '!'
    offer(tlle_pkg::ReqText, tlle_pkg::ChrLf, 32'h0);
    offer(tlle_pkg::ReqText, tlle_pkg::ChrTab, 32'h0);          // tab at column 0
    offer(tlle_pkg::ReqText, 8'h3F, 32'hCAFE_F00D);             // '?' itself
    offer(tlle_pkg::ReqText, tlle_pkg::ChrLf, 32'h0);
    offer(tlle_pkg::ReqText, tlle_pkg::ChrLf, 32'h0);

    // Narrow lines, one line kept: wraps, tab wrap, trimming, clear
    configure(8'd5, 8'd1);
    for (int n = 0; n < 5; n++) begin
      offer(tlle_pkg::ReqText, tlle_pkg::byte_t'(8'h61 + n), tlle_pkg::color_t'($urandom));
    end
    offer(tlle_pkg::ReqText, tlle_pkg::ChrTab, 32'h0);          // full line: tab opens a new one
    for (int n = 0; n < 6; n++) begin
      offer(tlle_pkg::ReqText, tlle_pkg::byte_t'(8'h66 + n), tlle_pkg::color_t'($urandom));
    end
    offer(tlle_pkg::ReqText, tlle_pkg::ChrLf, 32'h0);
    offer(tlle_pkg::ReqClear, 8'h00, 32'h0);

    // Random phases over a range of register settings
    run_phase(8'd1, 8'd1, 100, 1'b0);
    run_phase(8'd255, 8'd64, 125, 1'b1);
    run_phase(8'd5, 8'd2, 125, 1'b0);
    run_phase(8'd4, 8'd127, 125, 1'b0);
    run_phase(8'd7, 8'd3, 125, 1'b1);
    run_phase(8'd3, 8'd65, 100, 1'b0);
    run_phase(8'd2, 8'd0, 100, 1'b0);

    // Full-rate run of line breaks: ring overflow
    configure(8'd0, 8'd0);
    steady  = 1'b1;
    lf_sent = 0;
    while (lf_sent < OverflowLf) begin
      if ($urandom_range(7) == 0) begin
        offer(tlle_pkg::ReqText, tlle_pkg::byte_t'($urandom_range(8'h7E, 8'h21)),
              tlle_pkg::color_t'($urandom));
      end else begin
        offer(tlle_pkg::ReqText, tlle_pkg::ChrLf, tlle_pkg::color_t'($urandom));
        lf_sent++;
      end
    end
    steady = 1'b0;
    for (int n = 0; n < 40; n++) begin
      offer(tlle_pkg::ReqText, stream_byte(), tlle_pkg::color_t'($urandom));
    end

    run_phase(8'($urandom_range(12, 1)), 8'($urandom_range(64, 0)), 100, 1'b0);
    run_phase(8'($urandom_range(12, 1)), 8'($urandom_range(64, 0)), 100, 1'b0);
    run_phase(8'($urandom_range(255, 0)), 8'($urandom_range(64, 0)), 100, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/tlle_pkg.sv
sv/tlle_if.sv
sv/tlle_cnt_ram.sv
sv/text_line_layout_engine_unit.sv
tb/sv/text_line_layout_checker.sv
tb/sv/text_line_layout_engine_unit_test.sv
